/* hw/rtl/ndt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ndt_pkg;

    localparam int KEY_W     = 64;
    localparam int ST_W      = 3;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        IDX_ZERO = 2'd0,
        IDX_SLOT = 2'd1,
        IDX_RIDX = 2'd2
    } idx_sel_t;

    typedef enum logic [1:0] {
        KEY_REQ   = 2'd0,
        KEY_RDATA = 2'd1,
        KEY_ZERO  = 2'd2
    } key_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     rd_scan;
        logic     rd_last;
        logic     cap_slot;
        logic     wr_key;
        logic     wr_move;
        logic     out_load;
        status_t  out_st;
        idx_sel_t out_idx;
        key_sel_t out_key;
        logic     out_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ptr_lt_cnt;
        logic match;
        logic ridx_last;
        logic cnt_zero;
        logic cnt_full;
    } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ndt_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ndt_dpath
    import ndt_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int NAME_BYTES = 8
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [KEY_W-1:0]      key,
    input  wire dp_cmd_t         dcmd,
    output dp_sts_t              sts,
    output logic [ST_W-1:0]      status,
    output logic [KEY_W-1:0]     entry_key,
    output logic [IDX_OUT_W-1:0] entry_index,
    output logic [CNT_OUT_W-1:0] count,
    output logic                 last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);

    logic [KEY_W-1:0] mem_q [CAPACITY];

    logic [KEY_W-1:0]     key_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [IW-1:0]        slot_reg;
    logic [IW-1:0]        ridx_reg;
    logic [KEY_W-1:0]     rdata_reg;
    logic [ST_W-1:0]      status_reg;
    logic [KEY_W-1:0]     entry_key_reg;
    logic [IDX_OUT_W-1:0] entry_index_reg;
    logic [CNT_OUT_W-1:0] count_out_reg;
    logic                 last_reg;

    logic [CW-1:0]        cnt_m1;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    logic [KEY_W-1:0]     wr_data;
    logic [IW-1:0]        sel_idx;
    logic [KEY_W-1:0]     sel_key;

    assign cnt_m1  = count_reg - CW'(1);
    assign rd_addr = dcmd.rd_last ? cnt_m1[IW-1:0] : ptr_reg[IW-1:0];
    assign wr_addr = dcmd.wr_key ? count_reg[IW-1:0] : slot_reg;
    assign wr_data = dcmd.wr_key ? key_reg : rdata_reg;

    assign sts.ptr_lt_cnt = (ptr_reg < count_reg);
    assign sts.match      = (rdata_reg == key_reg);
    assign sts.ridx_last  = (CW'(ridx_reg) == cnt_m1);
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.cnt_full   = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        count_next = count_reg;
        if (dcmd.wr_key)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (dcmd.wr_move)
        begin
            count_next = cnt_m1;
        end
        ptr_next = ptr_reg;
        if (dcmd.load)
        begin
            ptr_next = '0;
        end
        else if (dcmd.rd_scan)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_comb
    begin
        case (dcmd.out_idx)
            IDX_SLOT: sel_idx = slot_reg;
            IDX_RIDX: sel_idx = ridx_reg;
            default:  sel_idx = '0;
        endcase
        case (dcmd.out_key)
            KEY_REQ:   sel_key = key_reg;
            KEY_RDATA: sel_key = rdata_reg;
            default:   sel_key = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Key table and its registered read port.
    always_ff @(posedge clk)
    begin
        if (dcmd.wr_key || dcmd.wr_move)
        begin
            mem_q[wr_addr] <= wr_data;
        end
        if (dcmd.rd_scan || dcmd.rd_last)
        begin
            rdata_reg <= mem_q[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.load)
        begin
            key_reg <= key & NAME_MASK;
        end
        if (dcmd.rd_scan)
        begin
            ridx_reg <= ptr_reg[IW-1:0];
        end
        if (dcmd.cap_slot)
        begin
            slot_reg <= ridx_reg;
        end
        else if (dcmd.wr_key)
        begin
            slot_reg <= count_reg[IW-1:0];
        end
        if (dcmd.out_load)
        begin
            status_reg      <= dcmd.out_st;
            entry_key_reg   <= sel_key;
            entry_index_reg <= IDX_OUT_W'(sel_idx);
            count_out_reg   <= CNT_OUT_W'(count_reg);
            last_reg        <= dcmd.out_last;
        end
    end

    assign status      = status_reg;
    assign entry_key   = entry_key_reg;
    assign entry_index = entry_index_reg;
    assign count       = count_out_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/ndt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ndt_ctrl
    import ndt_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  wire [OP_W-1:0] cmd,
    input  wire            out_ready,
    output logic           out_valid,
    input  wire dp_sts_t   sts,
    output dp_cmd_t        dcmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP,
        S_LST_RD,
        S_LST_OUT
    } state_t;

    state_t   state_reg, state_next;
    op_t      op_reg, op_next;
    logic     rdv_reg, rdv_next;
    status_t  res_st_reg, res_st_next;
    idx_sel_t res_idx_reg, res_idx_next;
    logic     out_valid_reg, out_valid_next;

    logic     out_free;
    logic     hit;
    logic     miss;

    assign out_free = !out_valid_reg || out_ready;
    assign hit      = rdv_reg && sts.match;
    assign miss     = (rdv_reg && !sts.match && sts.ridx_last) || (!rdv_reg && !sts.ptr_lt_cnt);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        rdv_next     = 1'b0;
        res_st_next  = res_st_reg;
        res_idx_next = res_idx_reg;
        dcmd         = '0;
        dcmd.out_st  = res_st_reg;
        dcmd.out_idx = res_idx_reg;
        dcmd.out_key = KEY_REQ;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dcmd.load = 1'b1;
                    op_next   = op_t'(cmd);
                    if (op_t'(cmd) != OP_LIST)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (sts.cnt_zero)
                    begin
                        res_st_next  = ST_EMPTY;
                        res_idx_next = IDX_ZERO;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        state_next = S_LST_RD;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    dcmd.cap_slot = 1'b1;
                    res_idx_next  = IDX_SLOT;
                    unique case (op_reg)
                        OP_CREATE:
                        begin
                            res_st_next = ST_EXISTS;
                            state_next  = S_RESP;
                        end
                        OP_DELETE:
                        begin
                            res_st_next = ST_OK;
                            state_next  = S_DEL_RD;
                        end
                        OP_SEARCH, OP_LIST:
                        begin
                            res_st_next = ST_OK;
                            state_next  = S_RESP;
                        end
                    endcase
                end
                else if (miss)
                begin
                    state_next = S_RESP;
                    if (op_reg == OP_CREATE && !sts.cnt_full)
                    begin
                        dcmd.wr_key  = 1'b1;
                        res_st_next  = ST_OK;
                        res_idx_next = IDX_SLOT;
                    end
                    else if (op_reg == OP_CREATE)
                    begin
                        res_st_next  = ST_FULL;
                        res_idx_next = IDX_ZERO;
                    end
                    else
                    begin
                        res_st_next  = ST_NOT_FOUND;
                        res_idx_next = IDX_ZERO;
                    end
                end
                else
                begin
                    dcmd.rd_scan = sts.ptr_lt_cnt;
                    rdv_next     = sts.ptr_lt_cnt;
                end
            end
            S_DEL_RD:
            begin
                dcmd.rd_last = 1'b1;
                state_next   = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                dcmd.wr_move = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    dcmd.out_load = 1'b1;
                    dcmd.out_key  = (res_st_reg == ST_EMPTY) ? KEY_ZERO : KEY_REQ;
                    dcmd.out_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_LST_RD:
            begin
                dcmd.rd_scan = 1'b1;
                state_next   = S_LST_OUT;
            end
            S_LST_OUT:
            begin
                dcmd.out_st  = ST_OK;
                dcmd.out_idx = IDX_RIDX;
                dcmd.out_key = KEY_RDATA;
                if (out_free)
                begin
                    dcmd.out_load = 1'b1;
                    dcmd.out_last = sts.ridx_last;
                    state_next    = sts.ridx_last ? S_IDLE : S_LST_RD;
                end
            end
        endcase

        out_valid_next = dcmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_CREATE;
            rdv_reg       <= 1'b0;
            res_st_reg    <= ST_OK;
            res_idx_reg   <= IDX_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            rdv_reg       <= rdv_next;
            res_st_reg    <= res_st_next;
            res_idx_reg   <= res_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/name_directory_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    cmd[1:0], key[63:0]
// output    out_valid / out_ready  status[2:0], entry_key[63:0], entry_index[3:0],
//                                  count[4:0], last
//
// A request is taken only in the idle state and is worked on alone. Create, delete
// and search scan the key table one slot per cycle; a list reads each entry and then
// emits it as a result, waiting while the output register is still full.
// Reset clears the entry count and the control state but not the key table. A result
// waits in the output register while the next request is accepted; the controller
// holds a new result back until that register is free.

module name_directory_table_top
    import ndt_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int NAME_BYTES = 8
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire [OP_W-1:0]       cmd,
    input  wire [KEY_W-1:0]      key,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [ST_W-1:0]      status,
    output logic [KEY_W-1:0]     entry_key,
    output logic [IDX_OUT_W-1:0] entry_index,
    output logic [CNT_OUT_W-1:0] count,
    output logic                 last
);

    dp_cmd_t dcmd;
    dp_sts_t sts;

    // The controller sequences the scan, the table update and the result.
    ndt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .dcmd      (dcmd)
    );

    // The datapath holds the key table, the entry count, the scan pointer and
    // the output register.
    ndt_dpath #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key),
        .dcmd        (dcmd),
        .sts         (sts),
        .status      (status),
        .entry_key   (entry_key),
        .entry_index (entry_index),
        .count       (count),
        .last        (last)
    );

    // Once a request is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> !in_ready
    ) else $error("request accepted while the block stayed idle");

    // A new key is never appended to a full table.
    a_no_append_when_full: assert property (
        @(posedge clk) disable iff (!rst_n) dcmd.wr_key |-> !sts.cnt_full
    ) else $error("key appended to a full table");

    // A delete only moves an entry when the table holds one.
    a_no_move_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n) dcmd.wr_move |-> !sts.cnt_zero
    ) else $error("entry moved in an empty table");

    // A result is never loaded over one that still waits to be taken.
    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n) dcmd.out_load |-> (!out_valid || out_ready)
    ) else $error("pending result overwritten");

endmodule

`default_nettype wire

/* test/tb_name_directory_table_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the name directory table. Requests (create, delete,
// search, list) go in over a valid/ready channel. Each accepted request is run
// through a local copy of the directory, and the results that it must produce
// are queued in order. A separate checker pops the oldest queued result for
// every result the block hands over and compares it field by field.
module tb_name_directory_table_top;
    import ndt_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int NAME_BYTES = 8;

    // Only the low NAME_BYTES bytes of a key take part in matching.
    localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);

    // A list walks the whole table one entry at a time, so this covers
    // anything still in flight once the last result has been seen.
    localparam int SETTLE_CYCLES    = 2 * CAPACITY + 8;
    localparam int LONG_HOLD_CYCLES = 300;
    // The longest quiet stretch in a correct run is the long hold above plus
    // the work still in flight, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int KEY_POOL_SIZE    = 24;

    typedef struct {
        status_t                status;
        logic [KEY_W-1:0]       entry_key;
        logic [IDX_OUT_W-1:0]   entry_index;
        logic [CNT_OUT_W-1:0]   count;
        logic                   last;
    } dir_result_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [OP_W-1:0]        cmd         = OP_CREATE;
    logic [KEY_W-1:0]       key         = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [ST_W-1:0]        status;
    logic [KEY_W-1:0]       entry_key;
    logic [IDX_OUT_W-1:0]   entry_index;
    logic [CNT_OUT_W-1:0]   count;
    logic                   last;

    // Local copy of the directory: slots 0 .. dir_count-1 are live.
    logic [KEY_W-1:0]       dir_keys [CAPACITY];
    int                     dir_count = 0;
    dir_result_t            expected_results [$];

    // Keys that random requests reuse, so that creates collide and deletes
    // and searches hit. Half of them differ from another by one bit.
    logic [KEY_W-1:0]       key_pool [KEY_POOL_SIZE];

    int                     errors      = 0;
    int                     idle_cycles = 0;
    bit                     steady_input    = 1'b0;
    bit                     steady_output   = 1'b0;
    bit                     hold_output_req = 1'b0;

    name_directory_table_top #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_key   (entry_key),
        .entry_index (entry_index),
        .count       (count),
        .last        (last)
    );

    // 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < dir_count; i++)
        begin
            if (dir_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    // The count field always reports the directory size after the request.
    function automatic dir_result_t make_result(status_t st, logic [KEY_W-1:0] k,
                                                int slot, logic is_last);
        dir_result_t res;
        res.status      = st;
        res.entry_key   = k;
        res.entry_index = IDX_OUT_W'(slot);
        res.count       = CNT_OUT_W'(dir_count);
        res.last        = is_last;
        return res;
    endfunction

    // Applies one accepted request to the local directory and queues the
    // results that the block must return for it.
    task automatic predict_request(op_t op, logic [KEY_W-1:0] raw_key);
        logic [KEY_W-1:0] k;
        int               slot;
        k    = raw_key & NAME_MASK;
        slot = find_key(k);
        case (op)
            OP_CREATE:
            begin
                if (slot >= 0)
                    expected_results.push_back(make_result(ST_EXISTS, k, slot, 1'b1));
                else if (dir_count >= CAPACITY)
                    expected_results.push_back(make_result(ST_FULL, k, 0, 1'b1));
                else
                begin
                    dir_keys[dir_count] = k;
                    dir_count++;
                    expected_results.push_back(make_result(ST_OK, k, dir_count - 1, 1'b1));
                end
            end
            OP_DELETE:
            begin
                if (slot < 0)
                    expected_results.push_back(make_result(ST_NOT_FOUND, k, 0, 1'b1));
                else
                begin
                    // The last entry fills the hole left by the deleted one.
                    dir_keys[slot] = dir_keys[dir_count - 1];
                    dir_count--;
                    expected_results.push_back(make_result(ST_OK, k, slot, 1'b1));
                end
            end
            OP_SEARCH:
            begin
                if (slot < 0)
                    expected_results.push_back(make_result(ST_NOT_FOUND, k, 0, 1'b1));
                else
                    expected_results.push_back(make_result(ST_OK, k, slot, 1'b1));
            end
            default:
            begin
                if (dir_count == 0)
                    expected_results.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                for (int i = 0; i < dir_count; i++)
                    expected_results.push_back(make_result(ST_OK, dir_keys[i], i,
                                                           i == dir_count - 1));
            end
        endcase
    endtask

    // Offers one request, holding it until the block takes it. Called at a
    // falling edge and returns at a falling edge with valid still high, so a
    // back-to-back request keeps valid up without a glitch. Anything that
    // pauses the input side has to drop valid first.
    task automatic send_request(op_t op, logic [KEY_W-1:0] k);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        predict_request(op, k);
        @(negedge clk);
    endtask

    // Stops offering requests until every queued result has come back.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Mostly reuses known keys; lookups and deletes favor keys that are stored
    // right now, so that most of them hit.
    function automatic logic [KEY_W-1:0] pick_key(bit prefer_stored);
        int r;
        r = $urandom_range(0, 99);
        if (prefer_stored && dir_count > 0 && r < 70)
            return dir_keys[$urandom_range(0, dir_count - 1)];
        if (r < 85)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // A list on an empty directory gives a single empty result.
    task automatic test_empty_directory();
        send_request(OP_LIST, {$urandom, $urandom});
    endtask

    // Extreme keys, a duplicate create, a search hit and a search miss.
    task automatic test_create_and_lookup();
        send_request(OP_CREATE, '0);
        send_request(OP_CREATE, {KEY_W{1'b1}});
        send_request(OP_CREATE, {KEY_W{1'b1}});
        send_request(OP_SEARCH, '0);
        send_request(OP_SEARCH, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    // Delete of an absent key, then delete of slot 0 with the last entry
    // moving down into it.
    task automatic test_delete_cases();
        send_request(OP_DELETE, 64'h5555_5555_5555_5555);
        send_request(OP_DELETE, '0);
    endtask

    // Fill the table, bounce a create off the full table, list all sixteen
    // entries, then delete the first slot and the last slot.
    task automatic test_fill_to_capacity();
        logic [KEY_W-1:0] fill_key;
        fill_key = 64'h5555_5555_5555_5554;
        while (dir_count < CAPACITY)
        begin
            fill_key = fill_key + 64'd1;
            send_request(OP_CREATE, fill_key);
        end
        send_request(OP_CREATE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_LIST, '0);
        send_request(OP_DELETE, {KEY_W{1'b1}});
        send_request(OP_DELETE, dir_keys[dir_count - 1]);
    endtask

    // Random requests; create_pct steers the directory toward full or empty.
    task automatic test_random_traffic(int n, int create_pct);
        op_t op;
        int  r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < create_pct)
                op = OP_CREATE;
            else if (r < create_pct + 10)
                op = OP_LIST;
            else if (r[0])
                op = OP_DELETE;
            else
                op = OP_SEARCH;
            send_request(op, pick_key(op != OP_CREATE));
        end
    endtask

    // The output side stops for a long stretch while requests keep coming, so
    // the output register and the controller fill and the input side stalls.
    task automatic test_output_backpressure();
        hold_output_req = 1'b1;
        send_request(OP_LIST, '0);
        repeat (6)
            send_request($urandom_range(0, 1) ? OP_CREATE : OP_SEARCH, pick_key(1'b1));
        wait_until_drained();
    endtask

    // Output side: random stalls, a steady mode with none, and the long hold
    // that the back-pressure test asks for, timed here in cycles.
    initial
    begin : result_acceptor
        int stall;
        forever
        begin
            @(negedge clk);
            if (hold_output_req)
            begin
                out_ready       <= 1'b0;
                hold_output_req  = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else if (steady_output)
                out_ready <= 1'b1;
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Every handed-over result is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        dir_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: status %0d, key %0h",
                         $time, status, entry_key);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", KEY_W'(want.status), KEY_W'(status));
                check_field("entry_key", want.entry_key, entry_key);
                check_field("entry_index", KEY_W'(want.entry_index), KEY_W'(entry_index));
                check_field("count", KEY_W'(want.count), KEY_W'(count));
                check_field("last", KEY_W'(want.last), KEY_W'(last));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_name_directory_table_top failed");
            $finish;
        end
        else
            idle_cycles = idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < KEY_POOL_SIZE / 2; i++)
        begin
            key_pool[i]                     = {$urandom, $urandom};
            key_pool[i + KEY_POOL_SIZE / 2] = key_pool[i] ^ (64'd1 << $urandom_range(0, 63));
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_directory();
        test_create_and_lookup();
        test_delete_cases();
        test_fill_to_capacity();

        // Create-heavy traffic keeps the table near full most of the time.
        test_random_traffic(75, 60);
        test_output_backpressure();
        // Delete-heavy traffic drains it down, with empty lists along the way.
        test_random_traffic(75, 25);
        wait_until_drained();

        // A stretch with no idling on either side.
        steady_input  = 1'b1;
        steady_output = 1'b1;
        test_random_traffic(40, 45);
        steady_input  = 1'b0;
        steady_output = 1'b0;

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_name_directory_table_top passed");
        else
            $display("tb_name_directory_table_top failed");
        $finish;
    end

endmodule
